// ===== rtl/amf_pkg.sv =====
`default_nettype none
package amf_pkg;

  typedef struct packed {
    logic       op;
    logic [7:0] row;
    logic [7:0] col;
    logic [7:0] pixel_value;
  } item_t;

  typedef struct packed {
    logic [7:0] filtered_value;
    logic       replaced;
    logic       bad_address;
  } result_t;

  // window bounds and target rank for one selection run
  typedef struct packed {
    logic       start;
    logic [7:0] r0;
    logic [7:0] r1;
    logic [7:0] c0;
    logic [7:0] c1;
    logic [5:0] rank;
  } sel_cmd_t;

  typedef struct packed {
    logic       done;
    logic [7:0] med;
    logic [7:0] mn;
    logic [7:0] mx;
    logic [7:0] rd_row;
    logic [7:0] rd_col;
  } sel_res_t;

  localparam logic       OP_WRITE  = 1'b0;
  localparam logic       OP_FILTER = 1'b1;
  localparam logic       MODE_BASIC = 1'b0;

  localparam logic [1:0] REG_MODE   = 2'd0;
  localparam logic [1:0] REG_WINDOW = 2'd1;
  localparam logic [1:0] REG_ROWS   = 2'd2;
  localparam logic [1:0] REG_COLS   = 2'd3;

endpackage
`default_nettype wire

// ===== rtl/median_and_adaptive_median_filter_unit.sv =====
`default_nettype none
// Write transaction: taken while idle; the unit stays idle and ready.
// Filter transaction: each window of n pixels takes 8 passes, one per bit,
// through the shared rank-select unit (one frame memory read a cycle).
// Basic mode: one window, half-width window_size/2. Adaptive mode adds a
// one-pixel pass for the centre pixel, then 3x3 up to that half-width.
// Synchronous reset clears control and settings; frame memory is not cleared.
module median_and_adaptive_median_filter_unit #(
  parameter int MAX_ROWS   = 256,
  parameter int MAX_COLS   = 256,
  parameter int MAX_WINDOW = 7
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             item_valid,
  output logic                  item_stall,
  input  wire amf_pkg::item_t   item,
  output logic                  result_valid,
  input  wire logic             result_stall,
  output amf_pkg::result_t      result,
  input  wire logic             psel,
  input  wire logic             penable,
  input  wire logic             pwrite,
  input  wire logic [3:0]       paddr,
  input  wire logic [31:0]      pwdata,
  output logic      [31:0]      prdata,
  output logic                  pready
);

  localparam int DEPTH = MAX_ROWS * MAX_COLS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_LAUNCH = 4'b0010,
    ST_RUN    = 4'b0100,
    ST_FINISH = 4'b1000
  } top_state_t;

  top_state_t        state;
  logic              filter_mode;
  logic [2:0]        window_size;
  logic [8:0]        image_rows, image_cols;
  logic [8:0]        rows, cols;
  logic [2:0]        win, half, s;
  logic [7:0]        rr, cc, orig;
  logic              mode;
  amf_pkg::result_t  res;
  amf_pkg::sel_cmd_t cmd;
  amf_pkg::sel_res_t sel;
  logic [7:0]        rdata;
  logic              mem_we;
  logic [AW-1:0]     mem_addr;
  logic              take, in_frame;
  logic [8:0]        rsum, csum;
  logic [7:0]        r0, r1, c0, c1;
  logic [3:0]        dimr, dimc;
  logic [7:0]        n;
  logic              in_range;

  assign rows = (13'(image_rows) > 13'(MAX_ROWS)) ? 9'(MAX_ROWS) : image_rows;
  assign cols = (13'(image_cols) > 13'(MAX_COLS)) ? 9'(MAX_COLS) : image_cols;
  assign win  = (5'(window_size) > 5'(MAX_WINDOW)) ? 3'(MAX_WINDOW) : window_size;
  assign half = win >> 1;

  assign pready = 1'b1;
  always_comb begin
    unique case (paddr[3:2])
      amf_pkg::REG_MODE:   prdata = {31'd0, filter_mode};
      amf_pkg::REG_WINDOW: prdata = {29'd0, window_size};
      amf_pkg::REG_ROWS:   prdata = {23'd0, image_rows};
      amf_pkg::REG_COLS:   prdata = {23'd0, image_cols};
      default:             prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      filter_mode <= 1'b0;
      window_size <= 3'd3;
      image_rows  <= 9'd256;
      image_cols  <= 9'd256;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[3:2])
        amf_pkg::REG_MODE:   filter_mode <= pwdata[0];
        amf_pkg::REG_WINDOW: window_size <= pwdata[2:0];
        amf_pkg::REG_ROWS:   image_rows  <= pwdata[8:0];
        amf_pkg::REG_COLS:   image_cols  <= pwdata[8:0];
        default: ;
      endcase
    end
  end

  assign item_stall = (state != ST_IDLE);
  assign take       = item_valid && !item_stall;
  assign in_frame   = ({1'b0, item.row} < rows) && ({1'b0, item.col} < cols);

  // clipped window bounds for half-width s around the latched pixel
  assign rsum = {1'b0, rr} + 9'(s);
  assign csum = {1'b0, cc} + 9'(s);
  assign r0   = ({1'b0, rr} >= 9'(s)) ? 8'(rsum - 9'(s) - 9'(s)) : 8'd0;
  assign c0   = ({1'b0, cc} >= 9'(s)) ? 8'(csum - 9'(s) - 9'(s)) : 8'd0;
  assign r1   = (rsum < rows) ? rsum[7:0] : 8'(rows - 9'd1);
  assign c1   = (csum < cols) ? csum[7:0] : 8'(cols - 9'd1);
  assign dimr = 4'(r1 - r0) + 4'd1;
  assign dimc = 4'(c1 - c0) + 4'd1;
  assign n    = dimr * dimc;

  assign cmd.start = (state == ST_LAUNCH);
  assign cmd.r0    = r0;
  assign cmd.r1    = r1;
  assign cmd.c0    = c0;
  assign cmd.c1    = c1;
  assign cmd.rank  = 6'(n >> 1);

  amf_select u_select (
    .clk   (clk),
    .rst   (rst),
    .cmd   (cmd),
    .rdata (rdata),
    .res   (sel)
  );

  assign mem_we = take && (item.op == amf_pkg::OP_WRITE) && in_frame;
  always_comb begin
    if (state == ST_IDLE) begin
      mem_addr = AW'(AW'(item.row) * AW'(MAX_COLS)) + AW'(item.col);
    end else begin
      mem_addr = AW'(AW'(sel.rd_row) * AW'(MAX_COLS)) + AW'(sel.rd_col);
    end
  end

  amf_frame_mem #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_frame_mem (
    .clk   (clk),
    .we    (mem_we),
    .addr  (mem_addr),
    .wdata (item.pixel_value),
    .rdata (rdata)
  );

  assign in_range = (sel.mn < sel.med) && (sel.med < sel.mx);

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      result_valid <= 1'b0;
    end else begin
      if (result_valid && !result_stall) begin
        result_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (take && item.op == amf_pkg::OP_FILTER) begin
            rr   <= item.row;
            cc   <= item.col;
            mode <= filter_mode;
            if (!in_frame) begin
              res   <= '{filtered_value: 8'd0, replaced: 1'b0, bad_address: 1'b1};
              state <= ST_FINISH;
            end else begin
              s     <= (filter_mode == amf_pkg::MODE_BASIC) ? half : 3'd0;
              state <= ST_LAUNCH;
            end
          end
        end
        ST_LAUNCH: state <= ST_RUN;
        ST_RUN: begin
          if (sel.done) begin
            if (mode == amf_pkg::MODE_BASIC) begin
              res   <= '{filtered_value: sel.med, replaced: 1'b1, bad_address: 1'b0};
              state <= ST_FINISH;
            end else if (s == 3'd0) begin
              orig <= sel.med;
              if (half == 3'd0) begin
                res   <= '{filtered_value: sel.med, replaced: 1'b0, bad_address: 1'b0};
                state <= ST_FINISH;
              end else begin
                s     <= 3'd1;
                state <= ST_LAUNCH;
              end
            end else if (in_range) begin
              res   <= '{filtered_value: sel.med, replaced: 1'b1, bad_address: 1'b0};
              state <= ST_FINISH;
            end else if (s == half) begin
              res   <= '{filtered_value: orig, replaced: 1'b0, bad_address: 1'b0};
              state <= ST_FINISH;
            end else begin
              s     <= s + 3'd1;
              state <= ST_LAUNCH;
            end
          end
        end
        ST_FINISH: begin
          if (!result_valid || !result_stall) begin
            result_valid <= 1'b1;
            result       <= res;
            state        <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  a_bad_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.bad_address |-> result.filtered_value == 8'd0 && !result.replaced)
    else $error("flagged transaction carries data");

  a_done_in_run: assert property (@(posedge clk) disable iff (rst)
    sel.done |-> state == ST_RUN)
    else $error("select finished outside run");

  a_launch_run: assert property (@(posedge clk) disable iff (rst)
    state == ST_LAUNCH |=> state == ST_RUN)
    else $error("launch not followed by run");

  a_write_idle: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> state == ST_IDLE)
    else $error("frame write while busy");

endmodule
`default_nettype wire

// ===== rtl/amf_frame_mem.sv =====
`default_nettype none
module amf_frame_mem #(
  parameter int DEPTH = 65536,
  parameter int AW    = 16
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] addr,
  input  wire logic [7:0]    wdata,
  output logic      [7:0]    rdata
);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule
`default_nettype wire

// ===== rtl/amf_select.sv =====
`default_nettype none
// rank select: one pass over the window per bit, most significant first
module amf_select (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire amf_pkg::sel_cmd_t cmd,
  input  wire logic [7:0]        rdata,
  output amf_pkg::sel_res_t      res
);

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_SCAN   = 4'b0010,
    S_DRAIN  = 4'b0100,
    S_DECIDE = 4'b1000
  } sel_state_t;

  sel_state_t state;
  logic [7:0] r0, r1, c0, c1, i, j;
  logic [5:0] rank, cnt;
  logic [2:0] bitpos;
  logic [7:0] pref, mn, mx;
  logic       rvld, done;
  logic [7:0] hi_mask;
  logic       hit;

  assign hi_mask = ~((8'd2 << bitpos) - 8'd1);
  assign hit     = (((rdata ^ pref) & hi_mask) == 8'd0) && !rdata[bitpos];

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      rvld  <= 1'b0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      rvld <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (cmd.start) begin
            r0     <= cmd.r0;
            r1     <= cmd.r1;
            c0     <= cmd.c0;
            c1     <= cmd.c1;
            i      <= cmd.r0;
            j      <= cmd.c0;
            rank   <= cmd.rank;
            cnt    <= '0;
            bitpos <= 3'd7;
            pref   <= '0;
            mn     <= 8'hFF;
            mx     <= 8'h00;
            state  <= S_SCAN;
          end
        end
        S_SCAN: begin
          rvld <= 1'b1;
          if (j == c1) begin
            j <= c0;
            if (i == r1) begin
              state <= S_DRAIN;
            end else begin
              i <= i + 8'd1;
            end
          end else begin
            j <= j + 8'd1;
          end
        end
        S_DRAIN: begin
          state <= S_DECIDE;
        end
        S_DECIDE: begin
          if (rank < cnt) begin
            pref[bitpos] <= 1'b0;
          end else begin
            pref[bitpos] <= 1'b1;
            rank         <= rank - cnt;
          end
          cnt <= '0;
          i   <= r0;
          j   <= c0;
          if (bitpos == 3'd0) begin
            done  <= 1'b1;
            state <= S_IDLE;
          end else begin
            bitpos <= bitpos - 3'd1;
            state  <= S_SCAN;
          end
        end
        default: state <= S_IDLE;
      endcase
      if (rvld) begin
        if (hit) begin
          cnt <= cnt + 6'd1;
        end
        if (bitpos == 3'd7) begin
          if (rdata < mn) mn <= rdata;
          if (rdata > mx) mx <= rdata;
        end
      end
    end
  end

  assign res.done   = done;
  assign res.med    = pref;
  assign res.mn     = mn;
  assign res.mx     = mx;
  assign res.rd_row = i;
  assign res.rd_col = j;

endmodule
`default_nettype wire
